[rtl/septic_field_accumulator_alu_assert.svh]
// Assertion shorthands for the septic accumulator checker.
`ifndef SEPTIC_FIELD_ACCUMULATOR_ALU_ASSERT_SVH
`define SEPTIC_FIELD_ACCUMULATOR_ALU_ASSERT_SVH

// same-cycle implication, disabled in reset
`define SFA_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sfa check failed");

// next-cycle implication, disabled in reset
`define SFA_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sfa check failed");

`endif

[rtl/sfa_pkg.sv]
package sfa_pkg;

   localparam int NCOEF = 7;
   localparam int NPROD = 2 * NCOEF - 1;
   localparam int CW    = 31;
   localparam int DW    = 224;
   localparam int UW    = 3;

   typedef logic [CW-1:0] coef_type;

   localparam coef_type P         = 31'd2013265921;
   localparam coef_type HALF_P    = 31'd1006632960;
   // Montgomery constants, R = 2^32
   localparam coef_type R2_MONT   = 31'd1172168163;
   localparam coef_type C5_MONT   = 31'd1342177270;
   localparam coef_type C2_MONT   = 31'd536870908;
   localparam coef_type CURVE_A   = 31'd2;
   localparam coef_type CURVE_B   = 31'd26;
   localparam int       CURVE_IDX = 5;

   typedef enum logic [2:0] {
      OP_LOAD  = 3'd0,
      OP_ADD   = 3'd1,
      OP_SUB   = 3'd2,
      OP_MUL   = 3'd3,
      OP_ADDB  = 3'd4,
      OP_SUBB  = 3'd5,
      OP_SCALE = 3'd6,
      OP_CURVE = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      TC_ZERO = 2'd0,
      TC_RECV = 2'd1,
      TC_SEND = 2'd2
   } tclass_type;

   // writeback control that rides along with a lane beat
   typedef struct packed {
      logic       valid;
      logic       to_bm;
      logic [2:0] shift;
   } wb_ctl_type;

   function automatic coef_type canon(input coef_type v);
      return (v >= P) ? v - P : v;
   endfunction

   function automatic coef_type fadd(input coef_type a, input coef_type b);
      logic [CW:0] s;
      s = {1'b0, a} + {1'b0, b};
      return (s >= {1'b0, P}) ? CW'(s - {1'b0, P}) : s[CW-1:0];
   endfunction

   function automatic coef_type fsub(input coef_type a, input coef_type b);
      logic [CW:0] s;
      s = {1'b0, a} + {1'b0, P} - {1'b0, b};
      return (a >= b) ? a - b : s[CW-1:0];
   endfunction

endpackage

[rtl/septic_field_accumulator_alu.sv]
// Curve runs two extension products back to back. A new item is taken only once
// the last one has reached the result register; seven Montgomery lanes take one
// row of the 7x7 product per cycle, and each phase drains the 2-stage lane pipe
// before the next.
// Reset (synchronous, active high) clears the accumulator to zero and empties the
// result register; an item is taken only in the idle state.
module septic_field_accumulator_alu import sfa_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [DW-1:0] req_tdata,   // operand_c0..operand_c6, 31 bits each, zero pad
   input  logic [UW-1:0] req_tuser,   // opcode
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [DW-1:0] rsp_tdata,   // acc_c0..acc_c6, 31 bits each, zero pad
   output logic [UW-1:0] rsp_tuser    // top_class[1:0], was_equal
);

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_CONV  = 8'b0000_0010,
      ST_MULT  = 8'b0000_0100,
      ST_FOLD  = 8'b0000_1000,
      ST_SCONV = 8'b0001_0000,
      ST_SCALE = 8'b0010_0000,
      ST_WAIT  = 8'b0100_0000,
      ST_FIN   = 8'b1000_0000
   } state_type;

   state_type  state_ff, state_in, ret_ff, ret_in;
   logic [2:0] cnt_ff, cnt_in;
   op_type     op_ff, op_in;
   logic       pass2_ff, pass2_in;
   logic       eq_ff, eq_in;
   coef_type   acc_ff  [NCOEF];
   coef_type   acc_in  [NCOEF];
   coef_type   opnd_ff [NCOEF];
   coef_type   opnd_in [NCOEF];
   coef_type   a_ff    [NCOEF];
   coef_type   a_in    [NCOEF];
   logic       rsp_valid_ff, rsp_valid_in;
   coef_type   rsp_data_ff [NCOEF];
   coef_type   rsp_data_in [NCOEF];
   tclass_type rsp_class_ff, rsp_class_in;
   logic       rsp_eq_ff, rsp_eq_in;

   coef_type   opnd_w [NCOEF];
   coef_type   nxt    [NCOEF];
   coef_type   lane_x [NCOEF];
   coef_type   lane_y [NCOEF];
   coef_type   lane_r [NCOEF];
   coef_type   prod   [NPROD];
   coef_type   bm     [NCOEF];
   wb_ctl_type issue;
   logic       clear, busy, eq_w;

   for (genvar g = 0; g < NCOEF; g++) begin : g_lane
      sfa_lane u_lane (
         .clock (clock),
         .x     (lane_x[g]),
         .y     (lane_y[g]),
         .res   (lane_r[g])
      );
   end

   sfa_merge u_merge (
      .clock (clock),
      .reset (reset),
      .issue (issue),
      .clear (clear),
      .res   (lane_r),
      .prod  (prod),
      .bm    (bm),
      .busy  (busy)
   );

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      eq_w = 1'b1;
      for (int j = 0; j < NCOEF; j++) begin
         opnd_w[j] = canon(req_tdata[j*CW +: CW]);
         if (opnd_w[j] != acc_ff[j]) eq_w = 1'b0;
      end
   end

   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      cnt_in       = cnt_ff;
      op_in        = op_ff;
      pass2_in     = pass2_ff;
      eq_in        = eq_ff;
      acc_in       = acc_ff;
      opnd_in      = opnd_ff;
      a_in         = a_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_class_in = rsp_class_ff;
      rsp_eq_in    = rsp_eq_ff;
      issue        = '0;
      clear        = 1'b0;
      nxt          = acc_ff;
      for (int j = 0; j < NCOEF; j++) begin
         lane_x[j] = '0;
         lane_y[j] = '0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               op_in    = op_type'(req_tuser);
               eq_in    = eq_w;
               opnd_in  = opnd_w;
               a_in     = acc_ff;
               clear    = 1'b1;
               pass2_in = 1'b0;
               cnt_in   = '0;
               unique case (op_type'(req_tuser))
                  OP_MUL, OP_CURVE:                          state_in = ST_CONV;
                  OP_SCALE:                                  state_in = ST_SCONV;
                  OP_LOAD, OP_ADD, OP_SUB, OP_ADDB, OP_SUBB: state_in = ST_FIN;
               endcase
            end
         end
         ST_CONV: begin
            // second factor into Montgomery form
            for (int j = 0; j < NCOEF; j++) begin
               lane_x[j] = (op_ff == OP_CURVE) ? acc_ff[j] : opnd_ff[j];
               lane_y[j] = R2_MONT;
            end
            issue    = '{valid: 1'b1, to_bm: 1'b1, shift: 3'd0};
            state_in = ST_WAIT;
            ret_in   = ST_MULT;
         end
         ST_MULT: begin
            for (int j = 0; j < NCOEF; j++) begin
               lane_x[j] = a_ff[cnt_ff];
               lane_y[j] = bm[j];
            end
            issue = '{valid: 1'b1, to_bm: 1'b0, shift: cnt_ff};
            if (cnt_ff == 3'(NCOEF - 1)) begin
               cnt_in   = '0;
               state_in = ST_WAIT;
               ret_in   = ST_FOLD;
            end else begin
               cnt_in = cnt_ff + 3'd1;
            end
         end
         ST_FOLD: begin
            // x^7 = 2x + 5: high columns times 5 onto i, times 2 onto i+1
            for (int j = 0; j < NCOEF; j++) begin
               if (cnt_ff == 3'd0) begin
                  lane_x[j] = (j <= NCOEF - 2) ? prod[(j <= NCOEF - 2) ? j + NCOEF : 0] : '0;
                  lane_y[j] = C5_MONT;
               end else begin
                  lane_x[j] = (j >= 1) ? prod[(j >= 1) ? j + NCOEF - 1 : 0] : '0;
                  lane_y[j] = C2_MONT;
               end
            end
            issue = '{valid: 1'b1, to_bm: 1'b0, shift: 3'd0};
            if (cnt_ff == 3'd1) begin
               cnt_in   = '0;
               state_in = ST_WAIT;
               ret_in   = ST_FIN;
            end else begin
               cnt_in = cnt_ff + 3'd1;
            end
         end
         ST_SCONV: begin
            for (int j = 0; j < NCOEF; j++) begin
               lane_x[j] = opnd_ff[0];
               lane_y[j] = R2_MONT;
            end
            issue    = '{valid: 1'b1, to_bm: 1'b1, shift: 3'd0};
            state_in = ST_WAIT;
            ret_in   = ST_SCALE;
         end
         ST_SCALE: begin
            for (int j = 0; j < NCOEF; j++) begin
               lane_x[j] = acc_ff[j];
               lane_y[j] = bm[j];
            end
            issue    = '{valid: 1'b1, to_bm: 1'b0, shift: 3'd0};
            state_in = ST_WAIT;
            ret_in   = ST_FIN;
         end
         ST_WAIT: begin
            if (!busy) begin
               if (ret_ff == ST_FIN && op_ff == OP_CURVE && !pass2_ff) begin
                  // square done: add 2 and multiply by acc again
                  for (int j = 0; j < NCOEF; j++) a_in[j] = prod[j];
                  a_in[0]  = fadd(prod[0], CURVE_A);
                  clear    = 1'b1;
                  pass2_in = 1'b1;
                  cnt_in   = '0;
                  state_in = ST_MULT;
               end else begin
                  state_in = ret_ff;
               end
            end
         end
         ST_FIN: begin
            unique case (op_ff)
               OP_LOAD: nxt = opnd_ff;
               OP_ADD:  for (int j = 0; j < NCOEF; j++) nxt[j] = fadd(acc_ff[j], opnd_ff[j]);
               OP_SUB:  for (int j = 0; j < NCOEF; j++) nxt[j] = fsub(acc_ff[j], opnd_ff[j]);
               OP_ADDB: nxt[0] = fadd(acc_ff[0], opnd_ff[0]);
               OP_SUBB: nxt[0] = fsub(acc_ff[0], opnd_ff[0]);
               OP_MUL, OP_SCALE: begin
                  for (int j = 0; j < NCOEF; j++) nxt[j] = prod[j];
               end
               OP_CURVE: begin
                  for (int j = 0; j < NCOEF; j++) nxt[j] = prod[j];
                  nxt[CURVE_IDX] = fadd(prod[CURVE_IDX], CURVE_B);
               end
            endcase
            if (!rsp_valid_ff || rsp_tready) begin
               acc_in       = nxt;
               rsp_data_in  = nxt;
               rsp_eq_in    = eq_ff;
               rsp_valid_in = 1'b1;
               if (nxt[NCOEF-1] == '0)
                  rsp_class_in = TC_ZERO;
               else if (nxt[NCOEF-1] <= HALF_P)
                  rsp_class_in = TC_RECV;
               else
                  rsp_class_in = TC_SEND;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ret_ff       <= ST_IDLE;
         cnt_ff       <= '0;
         pass2_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int j = 0; j < NCOEF; j++) acc_ff[j] <= '0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         cnt_ff       <= cnt_in;
         pass2_ff     <= pass2_in;
         rsp_valid_ff <= rsp_valid_in;
         acc_ff       <= acc_in;
      end
      op_ff        <= op_in;
      eq_ff        <= eq_in;
      opnd_ff      <= opnd_in;
      a_ff         <= a_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_class_ff <= rsp_class_in;
      rsp_eq_ff    <= rsp_eq_in;
   end

   always_comb begin
      rsp_tdata = '0;
      for (int j = 0; j < NCOEF; j++) rsp_tdata[j*CW +: CW] = rsp_data_ff[j];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = {rsp_eq_ff, rsp_class_ff};

endmodule

[rtl/sfa_lane.sv]
module sfa_lane import sfa_pkg::*; (
   input  logic     clock,
   input  coef_type x,
   input  coef_type y,
   output coef_type res
);

   logic [61:0] prod_ff, prod_in;
   logic [31:0] lo, m;
   logic [4:0]  m_top;
   logic [64:0] u;
   logic [31:0] t;
   coef_type    res_ff, res_in;

   assign prod_in = {31'd0, x} * {31'd0, y};

   // Montgomery reduction: -p^-1 mod 2^32 = 15*2^27 - 1, m*p by shifts
   always_comb begin
      lo     = prod_ff[31:0];
      m_top  = lo[4:0] * 5'd15;
      m      = {m_top, 27'd0} - lo;
      u      = {3'd0, prod_ff} + {2'd0, m, 31'd0} + {33'd0, m} - {6'd0, m, 27'd0};
      t      = u[63:32];
      res_in = (t >= {1'b0, P}) ? CW'(t - {1'b0, P}) : t[CW-1:0];
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      res_ff  <= res_in;
   end

   assign res = res_ff;

endmodule

[rtl/sfa_merge.sv]
module sfa_merge import sfa_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  wb_ctl_type issue,
   input  logic       clear,
   input  coef_type   res  [NCOEF],
   output coef_type   prod [NPROD],
   output coef_type   bm   [NCOEF],
   output logic       busy
);

   wb_ctl_type tag1_ff, tag2_ff;
   coef_type   prod_ff [NPROD];
   coef_type   prod_in [NPROD];
   coef_type   bm_ff   [NCOEF];
   coef_type   bm_in   [NCOEF];

   always_comb begin
      prod_in = prod_ff;
      bm_in   = bm_ff;
      if (clear) begin
         for (int k = 0; k < NPROD; k++) prod_in[k] = '0;
      end else if (tag2_ff.valid && tag2_ff.to_bm) begin
         bm_in = res;
      end else if (tag2_ff.valid) begin
         // lane j lands on product column shift + j
         for (int k = 0; k < NPROD; k++) begin
            for (int j = 0; j < NCOEF; j++) begin
               if (({1'b0, tag2_ff.shift} + 4'(j)) == 4'(k))
                  prod_in[k] = fadd(prod_ff[k], res[j]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff <= '0;
         tag2_ff <= '0;
      end else begin
         tag1_ff <= issue;
         tag2_ff <= tag1_ff;
      end
      prod_ff <= prod_in;
      bm_ff   <= bm_in;
   end

   assign prod = prod_ff;
   assign bm   = bm_ff;
   assign busy = tag1_ff.valid | tag2_ff.valid;

endmodule

[rtl/sfa_checker.sv]
`include "septic_field_accumulator_alu_assert.svh"

module sfa_checker import sfa_pkg::*; (
   input logic          clock,
   input logic          reset,
   input logic          req_tvalid,
   input logic          req_tready,
   input logic          rsp_tvalid,
   input logic          rsp_tready,
   input logic [DW-1:0] rsp_tdata,
   input logic [UW-1:0] rsp_tuser
);

   `SFA_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   `SFA_ASSERT_NOW(a_class_code, rsp_tvalid, rsp_tuser[1:0] != 2'd3)
   `SFA_ASSERT_NOW(a_class_zero, rsp_tvalid, (rsp_tuser[1:0] == 2'd0) == (rsp_tdata[216:186] == '0))
   `SFA_ASSERT_NOW(a_canon_c0, rsp_tvalid, rsp_tdata[30:0] < P)
   `SFA_ASSERT_NEXT(a_no_bypass, req_tvalid && req_tready, !$rose(rsp_tvalid))

endmodule

bind septic_field_accumulator_alu sfa_checker u_sfa_checker (.*);

[test/septic_field_accumulator_alu_tb.sv]
`timescale 1ns / 1ps

module septic_field_accumulator_alu_tb;
   import sfa_pkg::*;

   typedef logic [CW-1:0] vec7_type [NCOEF];

   typedef struct {
      vec7_type   acc;
      tclass_type tclass;
      logic       equal;
   } acc_result_type;

   int error_count = 0;

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   function automatic logic [CW-1:0] reduce_once(input logic [CW-1:0] v);
      return (v >= P) ? v - P : v;
   endfunction

   function automatic logic [CW-1:0] mod_add(input logic [CW-1:0] a, input logic [CW-1:0] b);
      longint s;
      s = longint'(a) + longint'(b);
      return (s >= longint'(P)) ? CW'(s - longint'(P)) : CW'(s);
   endfunction

   function automatic logic [CW-1:0] mod_sub(input logic [CW-1:0] a, input logic [CW-1:0] b);
      return (a >= b) ? a - b : CW'(longint'(a) + longint'(P) - longint'(b));
   endfunction

   function automatic logic [CW-1:0] mod_mul(input logic [CW-1:0] a, input logic [CW-1:0] b);
      longint unsigned t;
      t = longint'(a) * longint'(b);
      return CW'(t % longint'(P));
   endfunction

   function automatic vec7_type septic_mul(input vec7_type a, input vec7_type b);
      logic [CW-1:0] prod [NPROD];
      vec7_type r;
      for (int i = 0; i < NPROD; i++) prod[i] = '0;
      for (int i = 0; i < NCOEF; i++)
         for (int j = 0; j < NCOEF; j++)
            prod[i+j] = mod_add(prod[i+j], mod_mul(a[i], b[j]));
      // fold x^7 = 2x + 5 over the high terms, lowest first
      for (int i = NCOEF; i < NPROD; i++) begin
         prod[i-NCOEF]   = mod_add(prod[i-NCOEF], mod_mul(prod[i], 31'd5));
         prod[i-NCOEF+1] = mod_add(prod[i-NCOEF+1], mod_mul(prod[i], CURVE_A));
      end
      for (int i = 0; i < NCOEF; i++) r[i] = prod[i];
      return r;
   endfunction

   class acc_scoreboard;
      vec7_type       acc;
      acc_result_type pending[$];

      function new();
         for (int i = 0; i < NCOEF; i++) acc[i] = '0;
      endfunction

      function void note_item(input op_type op, input logic [DW-1:0] data);
         vec7_type opnd, nxt, sq;
         acc_result_type r;
         r.equal = 1'b1;
         for (int i = 0; i < NCOEF; i++) begin
            opnd[i] = reduce_once(data[i*CW +: CW]);
            if (opnd[i] != acc[i]) r.equal = 1'b0;
            nxt[i] = acc[i];
         end
         case (op)
            OP_LOAD:  nxt = opnd;
            OP_ADD:   for (int i = 0; i < NCOEF; i++) nxt[i] = mod_add(acc[i], opnd[i]);
            OP_SUB:   for (int i = 0; i < NCOEF; i++) nxt[i] = mod_sub(acc[i], opnd[i]);
            OP_MUL:   nxt = septic_mul(acc, opnd);
            OP_ADDB:  nxt[0] = mod_add(acc[0], opnd[0]);
            OP_SUBB:  nxt[0] = mod_sub(acc[0], opnd[0]);
            OP_SCALE: for (int i = 0; i < NCOEF; i++) nxt[i] = mod_mul(acc[i], opnd[0]);
            default: begin
               sq = septic_mul(acc, acc);
               sq[0] = mod_add(sq[0], CURVE_A);
               nxt = septic_mul(sq, acc);
               nxt[CURVE_IDX] = mod_add(nxt[CURVE_IDX], CURVE_B);
            end
         endcase
         acc = nxt;
         r.acc = nxt;
         if (nxt[NCOEF-1] == 0) r.tclass = TC_ZERO;
         else if (nxt[NCOEF-1] <= HALF_P) r.tclass = TC_RECV;
         else r.tclass = TC_SEND;
         pending.push_back(r);
      endfunction

      task check_result(input logic [DW-1:0] data, input logic [UW-1:0] user);
         acc_result_type e;
         if (pending.size() == 0) begin
            report_mismatch("unexpected result", 0, 0);
            return;
         end
         e = pending.pop_front();
         for (int i = 0; i < NCOEF; i++)
            if (data[i*CW +: CW] !== e.acc[i])
               report_mismatch($sformatf("acc_c%0d", i), data[i*CW +: CW], e.acc[i]);
         if (data[DW-1:NCOEF*CW] !== '0) report_mismatch("pad", data[DW-1:NCOEF*CW], 0);
         if (user[1:0] !== e.tclass) report_mismatch("top_class", user[1:0], e.tclass);
         if (user[2] !== e.equal) report_mismatch("was_equal", user[2], e.equal);
      endtask
   endclass

   logic          clock = 0;
   logic          reset = 1;
   logic          req_tvalid = 0;
   logic          req_tready;
   logic [DW-1:0] req_tdata = '0;
   logic [UW-1:0] req_tuser = '0;
   logic          rsp_tvalid;
   logic          rsp_tready = 0;
   logic [DW-1:0] rsp_tdata;
   logic [UW-1:0] rsp_tuser;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   bit stim_done = 0;

   acc_scoreboard board = new();

   septic_field_accumulator_alu DUT (.*);

   initial forever #5 clock = ~clock;

   initial begin
      #50ms;
      $display("[FAIL] regression broken");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_result(rsp_tdata, rsp_tuser);
      if (!reset && req_tvalid && req_tready) board.note_item(op_type'(req_tuser), req_tdata);
   end

   always @(negedge clock)
      rsp_tready <= !reset && ($urandom_range(99) >= recv_stall_pct);

   function automatic logic [CW-1:0] rand_coef();
      case ($urandom_range(9))
         0: return '0;
         1: return P - 1;
         2: return CW'($urandom_range(32'h7fff_ffff, P)); // non-canonical
         3: return CW'($urandom_range(3));
         default: return CW'($urandom_range(P - 1));
      endcase
   endfunction

   task automatic send_item(input op_type op, input logic [DW-1:0] data);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   task automatic send_fill(input op_type op, input logic [CW-1:0] v);
      logic [DW-1:0] d;
      d = '0;
      for (int i = 0; i < NCOEF; i++) d[i*CW +: CW] = v;
      send_item(op, d);
   endtask

   task automatic send_random(input op_type op);
      logic [DW-1:0] d;
      d = '0;
      for (int i = 0; i < NCOEF; i++) d[i*CW +: CW] = rand_coef();
      send_item(op, d);
   endtask

   initial begin
      int phase_pct [4][2];
      phase_pct = '{'{0, 0}, '{72, 0}, '{0, 72}, '{17, 17}};
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: extremes, each op, equality, non-canonical operands
      send_fill(OP_LOAD, '0);
      send_fill(OP_CURVE, '0);
      send_fill(OP_LOAD, P - 1);
      send_fill(OP_ADD, P - 1);
      send_fill(OP_SUB, P - 1);
      send_fill(OP_MUL, P - 1);
      send_fill(OP_LOAD, 31'h7fff_ffff);
      send_fill(OP_LOAD, 31'h7fff_ffff);
      send_fill(OP_ADDB, P);
      send_fill(OP_SUBB, P - 1);
      send_fill(OP_SCALE, P - 1);
      send_fill(OP_CURVE, P - 1);
      send_fill(OP_LOAD, HALF_P);
      send_fill(OP_LOAD, HALF_P + 1);
      send_fill(OP_MUL, 31'd1);
      send_fill(OP_SCALE, '0);
      send_fill(OP_SUBB, 31'd1);
      for (int k = 0; k < 8; k++) send_random(op_type'(k));

      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct  = phase_pct[ph][0];
         recv_stall_pct = phase_pct[ph][1];
         for (int n = 0; n < 470; n++) begin
            if ($urandom_range(19) == 0) begin
               // aim at the equality flag: resend the current accumulator
               logic [DW-1:0] d;
               d = '0;
               for (int i = 0; i < NCOEF; i++) d[i*CW +: CW] = board.acc[i];
               send_item(op_type'($urandom_range(7)), d);
            end else if ($urandom_range(9) == 0)
               send_random(OP_LOAD);
            else
               send_random(op_type'($urandom_range(7)));
         end
      end
      stim_done = 1;
   end

   initial begin
      wait (stim_done);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (error_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
